@@ design/etc_pkg.sv @@
// Shared types and constants for the exposure timer controller.
// No dependencies.
package etc_pkg;

  localparam int SecW  = 14;
  localparam int TickW = 16;
  localparam int StepW = 8;
  localparam int DispW = 15;

  localparam logic [TickW-1:0] TpsReset  = 16'd1000;
  localparam logic [StepW-1:0] StepReset = 8'd10;
  localparam logic [SecW-1:0]  CapReset  = 14'd6039;

  // Reciprocal of 60 scaled by 2**20, exact for any 14-bit seconds value.
  localparam int RecipW     = 15;
  localparam int RecipShift = 20;
  localparam logic [RecipW-1:0] Recip60 = 15'd17477;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_TIME_CLICK  = 3'd1,
    OP_TIME_LONG   = 3'd2,
    OP_TIME_IDLE   = 3'd3,
    OP_START_CLICK = 3'd4,
    OP_START_LONG  = 3'd5,
    OP_START_IDLE  = 3'd6,
    OP_MODE_SEL    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    PH_STANDBY  = 2'd0,
    PH_PAUSED   = 2'd1,
    PH_COUNTING = 2'd2,
    PH_ALERT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MD_OFF       = 2'd0,
    MD_COUNTDOWN = 2'd1,
    MD_STOPWATCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_TPS  = 2'd0,
    CFG_STEP = 2'd1,
    CFG_CAP  = 2'd2
  } cfg_idx_t;

  // Clamp a signed candidate value into 0..cap.
  function automatic logic [SecW-1:0] clamp_sec(input logic signed [SecW+1:0] v,
                                                 input logic [SecW-1:0] cap);
    logic [SecW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v >= $signed({2'b00, cap})) begin
      res = cap;
    end else begin
      res = v[SecW-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/exposure_timer_controller.sv @@
// Exposure timer controller top level: event decoding, timer state and result register.
// Depends on etc_pkg.
//
// The block takes one event per clock and returns exactly one result beat per
// event, in the cycle after acceptance. All state updates for an event are done in
// a single pass of logic from the state registers into the result register,
// so the sustained rate is one event per cycle; the input stalls only while a
// finished result waits in the output register and the output side stalls.
// Configuration writes are always ready and should be made while the block is idle.
module exposure_timer_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_operation,
  input  logic [1:0]                in_mode_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [etc_pkg::SecW-1:0]  out_seconds_value,
  output logic [etc_pkg::DispW-1:0] out_display_minsec,
  output logic [1:0]                out_run_state,
  output logic [1:0]                out_active_mode,
  output logic                      out_display_flash,
  output logic                      out_timer_led,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam int SecW  = etc_pkg::SecW;
  localparam int TickW = etc_pkg::TickW;
  localparam int StepW = etc_pkg::StepW;
  localparam int DispW = etc_pkg::DispW;
  localparam int ProdW = SecW + etc_pkg::RecipW;
  localparam int QW    = 9;
  localparam int RemW  = 6;

  logic [TickW-1:0] tps_r;
  logic [StepW-1:0] step_r;
  logic [SecW-1:0]  cap_r;

  etc_pkg::phase_t  phase_r, phase_nxt;
  etc_pkg::mode_t   mode_r, mode_nxt;
  logic [SecW-1:0]  sec_r, sec_nxt;
  logic [TickW-1:0] presc_r, presc_nxt;
  logic             held_r, held_nxt;
  logic             up_r, up_nxt;

  logic             out_valid_r;
  logic [SecW-1:0]  out_sec_r;
  logic [DispW-1:0] out_disp_r;
  logic [1:0]       out_phase_r;
  logic [1:0]       out_mode_r;
  logic             out_flash_r;
  logic             out_led_r;

  logic             in_accept;
  etc_pkg::op_t     op;
  logic [TickW-1:0] presc_inc;
  logic [SecW-1:0]  sec_step;
  logic signed [SecW+1:0] sec_s;
  logic signed [SecW+1:0] step_s;
  logic [ProdW-1:0] prod;
  logic [QW-1:0]    mins;
  logic [SecW-1:0]  rem_full;
  logic [RemW-1:0]  rem;
  logic [DispW-1:0] disp;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign op        = etc_pkg::op_t'(in_operation);

  assign sec_s     = $signed({2'b00, sec_r});
  assign step_s    = $signed({{(SecW + 2 - StepW){1'b0}}, step_r});
  assign presc_inc = presc_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    sec_nxt   = sec_r;
    presc_nxt = presc_r;
    held_nxt  = held_r;
    up_nxt    = up_r;
    sec_step  = '0;
    case (op)
      etc_pkg::OP_TICK: begin
        if (phase_r == etc_pkg::PH_COUNTING) begin
          if (presc_inc < tps_r) begin
            presc_nxt = presc_inc;
          end else begin
            presc_nxt = '0;
            if (sec_r != '0 && sec_r < cap_r) begin
              sec_step = etc_pkg::clamp_sec(up_r ? sec_s + 16'sd1 : sec_s - 16'sd1, cap_r);
              sec_nxt  = sec_step;
              if ((sec_step == '0 || sec_step >= cap_r) && mode_r != etc_pkg::MD_OFF) begin
                phase_nxt = etc_pkg::PH_ALERT;
              end
            end
          end
        end
      end
      etc_pkg::OP_TIME_CLICK, etc_pkg::OP_TIME_LONG: begin
        if (phase_r == etc_pkg::PH_STANDBY && mode_r == etc_pkg::MD_COUNTDOWN) begin
          sec_nxt = etc_pkg::clamp_sec(sec_s + step_s, cap_r);
          if (op == etc_pkg::OP_TIME_LONG) begin
            held_nxt = 1'b1;
          end
        end
      end
      etc_pkg::OP_TIME_IDLE: begin
        held_nxt = 1'b0;
      end
      etc_pkg::OP_START_CLICK: begin
        if (phase_r == etc_pkg::PH_STANDBY && mode_r == etc_pkg::MD_COUNTDOWN) begin
          sec_nxt = etc_pkg::clamp_sec(sec_s - step_s, cap_r);
        end else if (phase_r == etc_pkg::PH_COUNTING) begin
          if (mode_r != etc_pkg::MD_OFF) begin
            phase_nxt = etc_pkg::PH_PAUSED;
          end
        end else if (phase_r == etc_pkg::PH_PAUSED) begin
          if (mode_r != etc_pkg::MD_OFF) begin
            phase_nxt = etc_pkg::PH_COUNTING;
          end
        end
      end
      etc_pkg::OP_START_LONG: begin
        if (phase_r == etc_pkg::PH_STANDBY) begin
          if (held_r) begin
            sec_nxt = '0;
          end else if (mode_r != etc_pkg::MD_OFF) begin
            if (mode_r != etc_pkg::MD_COUNTDOWN) begin
              sec_nxt = etc_pkg::clamp_sec(16'sd1, cap_r);
            end
            phase_nxt = etc_pkg::PH_COUNTING;
          end
        end
      end
      etc_pkg::OP_START_IDLE: begin
      end
      etc_pkg::OP_MODE_SEL: begin
        if (in_mode_value == etc_pkg::MD_OFF || in_mode_value == etc_pkg::MD_COUNTDOWN ||
            in_mode_value == etc_pkg::MD_STOPWATCH) begin
          if (phase_r == etc_pkg::PH_STANDBY || in_mode_value == etc_pkg::MD_OFF) begin
            mode_nxt  = etc_pkg::mode_t'(in_mode_value);
            phase_nxt = etc_pkg::PH_STANDBY;
            up_nxt    = (in_mode_value != etc_pkg::MD_COUNTDOWN);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Minutes and seconds split by multiplication with a scaled reciprocal of 60.
  assign prod     = sec_nxt * etc_pkg::Recip60;
  assign mins     = prod[etc_pkg::RecipShift +: QW];
  assign rem_full = sec_nxt - ({{(SecW - QW){1'b0}}, mins} * 14'd60);
  assign rem      = rem_full[RemW-1:0];
  assign disp     = ({{(DispW - QW){1'b0}}, mins} * 15'd100) + {{(DispW - RemW){1'b0}}, rem};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= etc_pkg::TpsReset;
      step_r      <= etc_pkg::StepReset;
      cap_r       <= etc_pkg::CapReset;
      phase_r     <= etc_pkg::PH_STANDBY;
      mode_r      <= etc_pkg::MD_OFF;
      sec_r       <= '0;
      presc_r     <= '0;
      held_r      <= 1'b0;
      up_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (etc_pkg::cfg_idx_t'(cfg_index))
          etc_pkg::CFG_TPS:  tps_r  <= cfg_data[TickW-1:0];
          etc_pkg::CFG_STEP: step_r <= cfg_data[StepW-1:0];
          etc_pkg::CFG_CAP:  cap_r  <= cfg_data[SecW-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase_r     <= phase_nxt;
        mode_r      <= mode_nxt;
        sec_r       <= sec_nxt;
        presc_r     <= presc_nxt;
        held_r      <= held_nxt;
        up_r        <= up_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sec_r   <= sec_nxt;
      out_disp_r  <= disp;
      out_phase_r <= phase_nxt;
      out_mode_r  <= mode_nxt;
      out_flash_r <= (phase_nxt == etc_pkg::PH_PAUSED);
      out_led_r   <= (mode_nxt == etc_pkg::MD_COUNTDOWN);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seconds_value  = out_sec_r;
  assign out_display_minsec = out_disp_r;
  assign out_run_state      = out_phase_r;
  assign out_active_mode    = out_mode_r;
  assign out_display_flash  = out_flash_r;
  assign out_timer_led      = out_led_r;

`ifndef SYNTH
  a_run_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != etc_pkg::PH_STANDBY |-> mode_r != etc_pkg::MD_OFF)
    else $error("timer left standby with mode off");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r && out_phase_r == phase_r && out_sec_r == sec_r)
    else $error("accepted event did not produce a matching result");

  a_alert_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == etc_pkg::PH_ALERT && !(in_accept && op == etc_pkg::OP_MODE_SEL)
    |=> phase_r == etc_pkg::PH_ALERT)
    else $error("alert left without a mode selection");
`endif

endmodule
